/* hdl/rgbycc_pkg.sv */
// ----------------------------------------------------------------------------
// rgbycc_pkg: shared types and constants
// Transaction payload structs, register indexes, reset values and the
// position flags for the RGB pair to 4:2:0 YCbCr converter.
// ----------------------------------------------------------------------------
package rgbycc_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Configuration data width and reset values.
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 11'd720;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 11'd576;

  // One input transaction: two RGB24 pixels.
  typedef struct packed {
    logic [7:0] red_left;
    logic [7:0] green_left;
    logic [7:0] blue_left;
    logic [7:0] red_right;
    logic [7:0] green_right;
    logic [7:0] blue_right;
  } pix_pair_t;

  // One output transaction: two lumas, shared chroma and position marks.
  typedef struct packed {
    logic [7:0] luma_left;
    logic [7:0] luma_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       line_end;
    logic       frame_end;
  } ycc_out_t;

  // Position of the current pair within the frame.
  typedef struct packed {
    logic emit;
    logic line_end;
    logic frame_end;
  } pos_flags_t;

endpackage

/* hdl/rgbycc_position.sv */
// ----------------------------------------------------------------------------
// rgbycc_position: column pair and row counters
// Tracks the raster position of each incoming pair against the configured
// frame size and reports whether the pair is emitted and where it sits.
// ----------------------------------------------------------------------------
module rgbycc_position #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rgbycc_pkg::CFG_DATA_W-1:0]  frame_width,
  input  logic [rgbycc_pkg::CFG_DATA_W-1:0]  frame_height,
  input  logic                               advance,
  output rgbycc_pkg::pos_flags_t             flags
);

  localparam int PAIRS_MAX = MAX_WIDTH / 2;
  localparam int CW = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CW-1:0] column_pair_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] column_pair_count_next;
  logic [RW-1:0] row_count_next;

  logic [9:0]    pairs;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [RW-1:0] last_emit_row;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic          at_line_end;

  // Last valid positions from the configured size, clamped to the limits.
  always_comb begin
    pairs = frame_width[10:1];
    if (pairs == 10'd0) begin
      last_col = '0;
    end else if (int'(pairs) > PAIRS_MAX) begin
      last_col = CW'(PAIRS_MAX - 1);
    end else begin
      last_col = CW'(pairs - 10'd1);
    end

    if (frame_height == 11'd0) begin
      last_row = '0;
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(frame_height - 11'd1);
    end
    last_emit_row = last_row & ~RW'(1);
  end

  // Counters beyond a newly written size fall back to the last position.
  always_comb begin
    col_eff     = (column_pair_count > last_col) ? last_col : column_pair_count;
    row_eff     = (row_count > last_row) ? last_row : row_count;
    at_line_end = (col_eff == last_col);

    flags.emit      = ~row_eff[0];
    flags.line_end  = at_line_end;
    flags.frame_end = at_line_end && (row_eff == last_emit_row);

    if (at_line_end) begin
      column_pair_count_next = '0;
      row_count_next = (row_eff == last_row) ? '0 : row_eff + RW'(1);
    end else begin
      column_pair_count_next = col_eff + CW'(1);
      row_count_next = row_eff;
    end
  end

  // Counters step once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pair_count <= '0;
      row_count         <= '0;
    end else if (advance) begin
      column_pair_count <= column_pair_count_next;
      row_count         <= row_count_next;
    end
  end

endmodule

/* hdl/rgbycc_convert.sv */
// ----------------------------------------------------------------------------
// rgbycc_convert: BT.601 color conversion
// Computes two lumas and one pair of chroma values from an RGB pixel pair
// with 8-bit fixed-point constant multiplies.
// ----------------------------------------------------------------------------
module rgbycc_convert (
  input  rgbycc_pkg::pix_pair_t pix,
  output logic [7:0]            luma_left,
  output logic [7:0]            luma_right,
  output logic [7:0]            chroma_blue,
  output logic [7:0]            chroma_red
);

  // Luma with rounding: (77 r + 150 g + 29 b + 128) >> 8.
  function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [15:0] acc;
    acc = 16'd77 * {8'd0, r} + 16'd150 * {8'd0, g} + 16'd29 * {8'd0, b} + 16'd128;
    return acc[15:8];
  endfunction

  // Floor shift by 9, add the 128 offset and clamp to a byte.
  function automatic logic [7:0] chroma_of(input logic signed [18:0] weighted);
    logic signed [18:0] q;
    q = (weighted >>> 9) + 19'sd128;
    if (q > 19'sd255) begin
      return 8'd255;
    end else if (q < 19'sd0) begin
      return 8'd0;
    end else begin
      return q[7:0];
    end
  endfunction

  logic signed [18:0] rs;
  logic signed [18:0] gs;
  logic signed [18:0] bs;
  logic signed [18:0] cb_weighted;
  logic signed [18:0] cr_weighted;

  // Chroma works on the summed pair, rounding constant included.
  always_comb begin
    rs = $signed({10'd0, {1'b0, pix.red_left}   + {1'b0, pix.red_right}});
    gs = $signed({10'd0, {1'b0, pix.green_left} + {1'b0, pix.green_right}});
    bs = $signed({10'd0, {1'b0, pix.blue_left}  + {1'b0, pix.blue_right}});
    cb_weighted = 19'sd128 * bs - 19'sd43 * rs - 19'sd85 * gs + 19'sd511;
    cr_weighted = 19'sd128 * rs - 19'sd107 * gs - 19'sd21 * bs + 19'sd511;
  end

  assign luma_left   = luma_of(pix.red_left, pix.green_left, pix.blue_left);
  assign luma_right  = luma_of(pix.red_right, pix.green_right, pix.blue_right);
  assign chroma_blue = chroma_of(cb_weighted);
  assign chroma_red  = chroma_of(cr_weighted);

endmodule

/* hdl/rgb_pair_to_ycbcr420_line_double_core.sv */
// ----------------------------------------------------------------------------
// rgb_pair_to_ycbcr420_line_double_core: RGB pair to 4:2:0 YCbCr converter
// Converts raster-order RGB24 pixel pairs to BT.601 YCbCr with line-doubling
// deinterlace and end-of-line and end-of-frame marks.
// ----------------------------------------------------------------------------
// The block accepts one pixel pair per clock while the input register can
// take it. On acceptance the pair goes into the input register together with
// its position, taken from the column and row counters. When the result
// register is free, it loads the output of the conversion logic between the
// input register and the result register. Pairs on odd rows are
// consumed without a result; every even-row pair gives one result carrying
// both lumas and the pair's Cb and Cr. A stalled result holds in the output
// register while an empty input register still takes a new pair. Frame size is
// written through the configuration channel, which is always ready, and
// should be changed only while no transaction is in flight.
module rgb_pair_to_ycbcr420_line_double_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rgbycc_pkg::pix_pair_t               in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rgbycc_pkg::ycc_out_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgbycc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rgbycc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [rgbycc_pkg::CFG_DATA_W-1:0] frame_width;
  logic [rgbycc_pkg::CFG_DATA_W-1:0] frame_height;

  rgbycc_pkg::pos_flags_t  flags;
  rgbycc_pkg::pix_pair_t   stage_pix;
  logic                    stage_valid;
  logic                    stage_line_end;
  logic                    stage_frame_end;
  logic                    in_accept;
  logic                    out_free;
  logic                    stage_move;
  logic [7:0]              luma_left;
  logic [7:0]              luma_right;
  logic [7:0]              chroma_blue;
  logic [7:0]              chroma_red;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgbycc_pkg::FRAME_WIDTH_RESET;
      frame_height <= rgbycc_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rgbycc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        rgbycc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the output register is free.
  assign out_free   = !out_valid || out_ready;
  assign stage_move = stage_valid && out_free;
  assign in_ready   = !stage_valid || out_free;
  assign in_accept  = in_valid && in_ready;

  rgbycc_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .advance      (in_accept),
    .flags        (flags)
  );

  // Input register: only pairs that produce a result are held.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= flags.emit;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_pix       <= in_data;
      stage_line_end  <= flags.line_end;
      stage_frame_end <= flags.frame_end;
    end
  end

  rgbycc_convert u_convert (
    .pix         (stage_pix),
    .luma_left   (luma_left),
    .luma_right  (luma_right),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      out_data.luma_left   <= luma_left;
      out_data.luma_right  <= luma_right;
      out_data.chroma_blue <= chroma_blue;
      out_data.chroma_red  <= chroma_red;
      out_data.line_end    <= stage_line_end;
      out_data.frame_end   <= stage_frame_end;
    end
  end

`ifndef SYNTHESIS
  // A frame always ends on the last pair of a line.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.frame_end || out_data.line_end))
    else $error("frame_end without line_end");

  // An empty input register never blocks the input.
  assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> in_ready)
    else $error("input stalled with empty input register");

  // A pair leaving the input register shows up as a result.
  assert property (@(posedge clk) disable iff (rst)
    stage_move |=> out_valid)
    else $error("result lost between input and result registers");

  // A held result is not overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule
